// ----- hdl/tcq_pkg.sv -----
package tcq_pkg;

  localparam int unsigned CQ_DEPTH = 16;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PENDING_W = 5;
  localparam int unsigned SPAN_W    = 31;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 88;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PULL   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTHING  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef enum logic {
    ALU_LT,
    ALU_SUBSAT
  } tcq_alu_op_e;

  typedef struct packed {
    logic signed [TIME_W-1:0] evt_time;
    logic [TAG_W-1:0]         evt_tag;
  } tcq_entry_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [TIME_W-1:0] time_value;
    logic [TAG_W-1:0]         command_tag;
  } tcq_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [TAG_W-1:0]         out_tag;
    logic signed [TIME_W-1:0] out_time;
    logic [PENDING_W-1:0]     pending_count;
    logic [SPAN_W-1:0]        span_time;
  } tcq_result_t;

endpackage

// ----- hdl/timed_command_queue.sv -----
// Operation: insert into a non-empty queue walks from the tail toward the head, shifting each
//   later entry up one slot; pop or pull takes the head and shifts every entry behind it down;
//   a pop not yet due leaves the queue as it is. Insert into an empty or full queue, pop or pull
//   on an empty queue and the unused code go straight to S_FIN, where each result waits.
// Throughput: one request at a time, the next one accepted in the cycle after the result loads;
//   the entry store does one write and one registered read per cycle, moving one entry each.
// Reset: asynchronous, active low; empties the queue and clears time_offset to zero.
module timed_command_queue
  import tcq_pkg::*;
#(
  parameter int unsigned DEPTH = CQ_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] cmd, [33:2] time_value, [49:34] command_tag, [55:50] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] status, [17:2] out_tag, [49:18] out_time, [54:50] pending_count,
  // [85:55] span_time, [87:86] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // time_offset register write
  input  logic                  cfg_we_i,
  input  logic [TIME_W-1:0]     cfg_wdata_i
);

  logic signed [TIME_W-1:0] time_offset_q;
  tcq_req_t    req;
  tcq_result_t res;
  logic        eng_idle;
  logic        res_valid;
  logic        res_ready;
  logic        m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  // Hold the offset until the next write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_offset_q <= '0;
    end else if (cfg_we_i) begin
      time_offset_q <= cfg_wdata_i;
    end
  end

  // Unpack the request fields from the lowest bit up.
  assign req.cmd         = s_axis_tdata[CMD_W-1:0];
  assign req.time_value  = s_axis_tdata[CMD_W+TIME_W-1:CMD_W];
  assign req.command_tag = s_axis_tdata[CMD_W+TIME_W+TAG_W-1:CMD_W+TIME_W];

  // The engine takes a request only while it sits idle.
  assign s_axis_tready = eng_idle;

  tcq_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid & eng_idle),
    .req_i       (req),
    .offset_i    (time_offset_q),
    .idle_o      (eng_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load a new result whenever the slot is free or being drained,
  // so the engine can return to idle while the previous result waits downstream.
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= {2'b00, res.span_time, res.pending_count, res.out_time,
                   res.out_tag, res.status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- hdl/tcq_alu.sv -----
module tcq_alu
  import tcq_pkg::*;
(
  input  tcq_alu_op_e              op_i,
  input  logic signed [TIME_W-1:0] a_i,
  input  logic signed [TIME_W-1:0] b_i,
  output logic signed [TIME_W-1:0] y_o
);

  logic signed [TIME_W:0] diff;

  // One sign-extended subtract serves both operations.
  assign diff = {a_i[TIME_W-1], a_i} - {b_i[TIME_W-1], b_i};

  always_comb begin
    unique case (op_i)
      ALU_LT: begin
        y_o = {{(TIME_W-1){1'b0}}, diff[TIME_W]};
      end
      ALU_SUBSAT: begin
        if (diff[TIME_W] != diff[TIME_W-1]) begin
          // clamp on overflow
          y_o = diff[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
        end else begin
          y_o = diff[TIME_W-1:0];
        end
      end
      default: y_o = '0;
    endcase
  end

endmodule

// ----- hdl/tcq_engine.sv -----
module tcq_engine
  import tcq_pkg::*;
#(
  parameter int unsigned DEPTH = CQ_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  tcq_req_t                 req_i,
  input  logic signed [TIME_W-1:0] offset_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output tcq_result_t              res_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_RM_HEAD,
    S_RM_SHIFT,
    S_FIN
  } state_e;

  // Entry store, one write and one registered read per cycle
  tcq_entry_t mem [DEPTH];
  tcq_entry_t rdata_q;
  logic       mem_we;
  logic       mem_re;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  tcq_entry_t mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] idx_q, idx_d;
  logic signed [TIME_W-1:0] tv_q, tv_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic signed [TIME_W-1:0] tail_q, tail_d;
  logic pop_q, pop_d;
  logic [STATUS_W-1:0] status_q, status_d;
  tcq_entry_t out_q, out_d;

  tcq_alu_op_e alu_op;
  logic signed [TIME_W-1:0] alu_a, alu_b, alu_y;
  logic alu_lt;
  logic [IW-1:0] last_idx;

  tcq_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  assign alu_lt   = alu_y[0];
  assign last_idx = IW'(count_q - CW'(1));

  always_comb begin
    alu_op = (state_q == S_IDLE) ? ALU_SUBSAT : ALU_LT;
    alu_a  = (state_q == S_IDLE) ? req_i.time_value : tv_q;
    alu_b  = (state_q == S_IDLE) ? offset_i : rdata_q.evt_time;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    tv_d      = tv_q;
    tag_d     = tag_q;
    tail_d    = tail_q;
    pop_d     = pop_q;
    status_d  = status_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          tag_d    = req_i.command_tag;
          pop_d    = (req_i.cmd == CMD_POP);
          tv_d     = (req_i.cmd == CMD_POP) ? alu_y : req_i.time_value;
          out_d    = '0;
          status_d = ST_NOTHING;
          unique case (req_i.cmd)
            CMD_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_FIN;
              end else if (count_q == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '{evt_time: req_i.time_value, evt_tag: req_i.command_tag};
                tail_d    = req_i.time_value;
                count_d   = CW'(1);
                status_d  = ST_INSERTED;
                state_d   = S_FIN;
              end else begin
                // walk from the tail toward the head
                mem_re    = 1'b1;
                mem_raddr = last_idx;
                idx_d     = last_idx;
                state_d   = S_INS;
              end
            end
            CMD_POP, CMD_PULL: begin
              if (count_q == '0) begin
                state_d = S_FIN;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_d     = '0;
                state_d   = S_RM_HEAD;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(idx_q + IW'(1));
        if (alu_lt) begin
          // shift this entry up one slot
          mem_wdata = rdata_q;
          if (idx_q == '0) begin
            state_d = S_INS_LAST;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IW'(idx_q - IW'(1));
            idx_d     = IW'(idx_q - IW'(1));
          end
        end else begin
          mem_wdata = '{evt_time: tv_q, evt_tag: tag_q};
          if (idx_q == last_idx) begin
            tail_d = tv_q;
          end
          count_d  = CW'(count_q + CW'(1));
          status_d = ST_INSERTED;
          state_d  = S_FIN;
        end
      end

      S_INS_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{evt_time: tv_q, evt_tag: tag_q};
        count_d   = CW'(count_q + CW'(1));
        status_d  = ST_INSERTED;
        state_d   = S_FIN;
      end

      S_RM_HEAD: begin
        if (pop_q && alu_lt) begin
          state_d = S_FIN;
        end else begin
          out_d    = rdata_q;
          status_d = ST_REMOVED;
          if (count_q == CW'(1)) begin
            count_d = '0;
            state_d = S_FIN;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IW'(1);
            idx_d     = IW'(1);
            state_d   = S_RM_SHIFT;
          end
        end
      end

      S_RM_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(idx_q - IW'(1));
        mem_wdata = rdata_q;
        if (idx_q == last_idx) begin
          count_d = CW'(count_q - CW'(1));
          state_d = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(idx_q + IW'(1));
          idx_d     = IW'(idx_q + IW'(1));
        end
      end

      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      pop_q    <= 1'b0;
      status_q <= ST_NOTHING;
      tv_q     <= '0;
      tag_q    <= '0;
      tail_q   <= '0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      pop_q    <= pop_d;
      status_q <= status_d;
      tv_q     <= tv_d;
      tag_q    <= tag_d;
      tail_q   <= tail_d;
      out_q    <= out_d;
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FIN);

  always_comb begin
    res_o.status        = status_q;
    res_o.out_tag       = out_q.evt_tag;
    res_o.out_time      = out_q.evt_time;
    res_o.pending_count = PENDING_W'(count_q);
    // the tail entry is the latest stored time
    if (count_q == '0 || tail_q[TIME_W-1]) begin
      res_o.span_time = '0;
    end else begin
      res_o.span_time = tail_q[SPAN_W-1:0];
    end
  end

endmodule
